>>> rtl/pyc_pkg.sv
// Shared constants for the planar 4:2:0 crop block.
package pyc_pkg;

	localparam int CFG_W   = 13;
	localparam int IDX_W   = 3;
	localparam int PIX_W   = 8;
	localparam int PLANE_W = 2;

	localparam logic [IDX_W-1:0] REG_IN_WIDTH    = 3'd0;
	localparam logic [IDX_W-1:0] REG_IN_HEIGHT   = 3'd1;
	localparam logic [IDX_W-1:0] REG_CROP_LEFT   = 3'd2;
	localparam logic [IDX_W-1:0] REG_CROP_RIGHT  = 3'd3;
	localparam logic [IDX_W-1:0] REG_CROP_TOP    = 3'd4;
	localparam logic [IDX_W-1:0] REG_CROP_BOTTOM = 3'd5;

	localparam logic [PLANE_W-1:0] PLANE_Y = 2'd0;
	localparam logic [PLANE_W-1:0] PLANE_U = 2'd1;
	localparam logic [PLANE_W-1:0] PLANE_V = 2'd2;

	localparam logic [CFG_W-1:0] RST_IN_WIDTH  = 13'd640;
	localparam logic [CFG_W-1:0] RST_IN_HEIGHT = 13'd480;

endpackage

>>> rtl/planar_yuv420_crop.sv
// Crop window on a planar 4:2:0 byte stream (Y plane, then U, then V).
// A kept byte reaches the master side through the input register and then the output register.
// Throughput: one byte per cycle while the master side accepts; input register, window compare, output register.
// Window bounds are derived from the configuration registers and held in bound registers.
// Reset (arst_n low, asynchronous): counters to luma origin, pipeline empty,
// registers to 640 x 480 with no crop.
module planar_yuv420_crop #(
	parameter int MAX_DIM = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pyc_pkg::IDX_W-1:0]     cfg_index,
	input  logic [pyc_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [pyc_pkg::PIX_W-1:0]     s_axis_tdata,   // [7:0] pixel_in
	input  logic                          s_axis_tuser,   // [0] frame_start
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [pyc_pkg::PIX_W-1:0]     m_axis_tdata,   // [7:0] pixel_out
	output logic [pyc_pkg::PLANE_W-1:0]   m_axis_tuser,   // [1:0] plane
	output logic                          m_axis_tlast    // last_of_frame
);

	localparam int CW    = $clog2(MAX_DIM);
	localparam int DW    = $clog2(MAX_DIM + 1);
	localparam int CalcW = ((DW > pyc_pkg::CFG_W) ? DW : pyc_pkg::CFG_W) + 1;

	typedef struct packed {
		logic [DW-1:0] last_col;
		logic [DW-1:0] last_row;
		logic [DW-1:0] x0;
		logic [DW-1:0] x1;
		logic [DW-1:0] y0;
		logic [DW-1:0] y1;
	} bounds_t;

	logic [pyc_pkg::CFG_W-1:0] in_width_q, in_height_q;
	logic [pyc_pkg::CFG_W-1:0] crop_left_q, crop_right_q, crop_top_q, crop_bottom_q;

	bounds_t bnd_y_q, bnd_c_q, bnd_y_d, bnd_c_d, bnd;

	logic [CalcW-1:0] w, h, l, r, t, b;

	logic                        valid_s1;
	logic [pyc_pkg::PIX_W-1:0]   pix_s1;
	logic                        start_s1;

	logic [CW-1:0]               col_q, row_q;
	logic [pyc_pkg::PLANE_W-1:0] plane_q;
	logic [CW-1:0]               col, row, col_nxt, row_nxt;
	logic [pyc_pkg::PLANE_W-1:0] plane, plane_nxt;
	logic [DW-1:0]               colx, rowx;
	logic                        keep, last, advance;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_width_q    <= pyc_pkg::RST_IN_WIDTH;
			in_height_q   <= pyc_pkg::RST_IN_HEIGHT;
			crop_left_q   <= '0;
			crop_right_q  <= '0;
			crop_top_q    <= '0;
			crop_bottom_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				pyc_pkg::REG_IN_WIDTH:    in_width_q    <= cfg_data;
				pyc_pkg::REG_IN_HEIGHT:   in_height_q   <= cfg_data;
				pyc_pkg::REG_CROP_LEFT:   crop_left_q   <= cfg_data;
				pyc_pkg::REG_CROP_RIGHT:  crop_right_q  <= cfg_data;
				pyc_pkg::REG_CROP_TOP:    crop_top_q    <= cfg_data;
				pyc_pkg::REG_CROP_BOTTOM: crop_bottom_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Window bounds for luma and chroma
	always_comb begin
		w = CalcW'({in_width_q[pyc_pkg::CFG_W-1:1], 1'b0});
		h = CalcW'({in_height_q[pyc_pkg::CFG_W-1:1], 1'b0});
		if (w < CalcW'(2)) w = CalcW'(2);
		if (w > CalcW'(MAX_DIM)) w = CalcW'(MAX_DIM);
		if (h < CalcW'(2)) h = CalcW'(2);
		if (h > CalcW'(MAX_DIM)) h = CalcW'(MAX_DIM);
		l = CalcW'({crop_left_q[pyc_pkg::CFG_W-1:1], 1'b0});
		r = CalcW'({crop_right_q[pyc_pkg::CFG_W-1:1], 1'b0});
		t = CalcW'({crop_top_q[pyc_pkg::CFG_W-1:1], 1'b0});
		b = CalcW'({crop_bottom_q[pyc_pkg::CFG_W-1:1], 1'b0});
		// excess crop counts as no crop on that axis
		if (l + r > w) begin
			l = '0;
			r = '0;
		end
		if (t + b > h) begin
			t = '0;
			b = '0;
		end
		bnd_y_d.last_col = DW'(w - CalcW'(1));
		bnd_y_d.last_row = DW'(h - CalcW'(1));
		bnd_y_d.x0       = DW'(l);
		bnd_y_d.x1       = DW'(w - r);
		bnd_y_d.y0       = DW'(t);
		bnd_y_d.y1       = DW'(h - b);
		bnd_c_d.last_col = DW'((w >> 1) - CalcW'(1));
		bnd_c_d.last_row = DW'((h >> 1) - CalcW'(1));
		bnd_c_d.x0       = DW'(l >> 1);
		bnd_c_d.x1       = DW'((w >> 1) - (r >> 1));
		bnd_c_d.y0       = DW'(t >> 1);
		bnd_c_d.y1       = DW'((h >> 1) - (b >> 1));
	end

	always_ff @(posedge clk) begin
		bnd_y_q <= bnd_y_d;
		bnd_c_q <= bnd_c_d;
	end

	assign advance       = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			pix_s1   <= s_axis_tdata;
			start_s1 <= s_axis_tuser;
		end
	end

	// Position, window test and counter advance for the byte in stage 1
	always_comb begin
		col   = start_s1 ? '0 : col_q;
		row   = start_s1 ? '0 : row_q;
		plane = start_s1 ? pyc_pkg::PLANE_Y : plane_q;
		if (plane > pyc_pkg::PLANE_V) plane = pyc_pkg::PLANE_Y;
		bnd  = (plane == pyc_pkg::PLANE_Y) ? bnd_y_q : bnd_c_q;
		colx = DW'(col);
		rowx = DW'(row);
		keep = (colx >= bnd.x0) && (colx < bnd.x1) && (rowx >= bnd.y0) && (rowx < bnd.y1);
		last = (plane == pyc_pkg::PLANE_V) && (colx + DW'(1) == bnd.x1)
			&& (rowx + DW'(1) == bnd.y1);
		col_nxt   = col;
		row_nxt   = row;
		plane_nxt = plane;
		// a counter at or past its bound wraps, also after a size change
		if (colx >= bnd.last_col) begin
			col_nxt = '0;
			if (rowx >= bnd.last_row) begin
				row_nxt   = '0;
				plane_nxt = (plane >= pyc_pkg::PLANE_V) ? pyc_pkg::PLANE_Y
					: plane + pyc_pkg::PLANE_W'(1);
			end else begin
				row_nxt = row + CW'(1);
			end
		end else begin
			col_nxt = col + CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			plane_q <= pyc_pkg::PLANE_Y;
		end else if (valid_s1 && advance) begin
			col_q   <= col_nxt;
			row_q   <= row_nxt;
			plane_q <= plane_nxt;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (advance) begin
			m_axis_tvalid <= valid_s1 && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && keep) begin
			m_axis_tdata <= pix_s1;
			m_axis_tuser <= plane;
			m_axis_tlast <= last;
		end
	end

`ifndef NO_ASSERTIONS
	a_last_only_v: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser == pyc_pkg::PLANE_V))
		else $error("last marker on a byte outside the V plane");

	a_kept_reaches_out: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance && keep) |=> m_axis_tvalid)
		else $error("kept byte did not reach the output register");

	a_stall_holds_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(col_q) && $stable(row_q)
			&& $stable(plane_q)))
		else $error("position counters moved while stage 1 was stalled");

	a_plane_range: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance) |=> (plane_q <= pyc_pkg::PLANE_V))
		else $error("plane counter left the V plane without wrapping");
`endif

endmodule

>>> tb/planar_yuv420_crop_chk.sv
// Checker: predicts the cropped 4:2:0 byte stream and compares it with the master side.
`timescale 1ns / 1ps
module planar_yuv420_crop_chk #(
	parameter int MAX_DIM = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pyc_pkg::IDX_W-1:0]     cfg_index,
	input  logic [pyc_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [pyc_pkg::PIX_W-1:0]     s_tdata,
	input  logic                          s_tuser,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [pyc_pkg::PIX_W-1:0]     m_tdata,
	input  logic [pyc_pkg::PLANE_W-1:0]   m_tuser,
	input  logic                          m_tlast,
	output int                            fail_count,
	output int                            pending
);

	typedef struct packed {
		logic [pyc_pkg::PIX_W-1:0]   pix;
		logic [pyc_pkg::PLANE_W-1:0] plane;
		logic                        last;
	} kept_byte_t;

	kept_byte_t kept_q[$];

	logic [pyc_pkg::CFG_W-1:0] width_reg, height_reg, left_reg, right_reg, top_reg, bottom_reg;
	int unsigned col_pos, row_pos;
	logic [pyc_pkg::PLANE_W-1:0] plane_pos;

	function automatic int unsigned even_val(input logic [pyc_pkg::CFG_W-1:0] v);
		return {v[pyc_pkg::CFG_W-1:1], 1'b0};
	endfunction

	function automatic int unsigned legal_dim(input logic [pyc_pkg::CFG_W-1:0] v);
		int unsigned d;
		d = even_val(v);
		if (d < 2) d = 2;
		if (d > MAX_DIM) d = MAX_DIM;
		return d;
	endfunction

	// Decide whether one incoming byte lands in the window, then advance the position.
	task automatic crop_step(input logic [pyc_pkg::PIX_W-1:0] pix, input logic start);
		int unsigned w, h, l, r, t, b, pw, ph, x0, x1, y0, y1;
		kept_byte_t k;
		w = legal_dim(width_reg);
		h = legal_dim(height_reg);
		l = even_val(left_reg);
		r = even_val(right_reg);
		t = even_val(top_reg);
		b = even_val(bottom_reg);
		// drop a crop pair that does not fit
		if (l + r > w) begin
			l = 0;
			r = 0;
		end
		if (t + b > h) begin
			t = 0;
			b = 0;
		end
		if (start) begin
			col_pos = 0;
			row_pos = 0;
			plane_pos = pyc_pkg::PLANE_Y;
		end
		if (plane_pos > pyc_pkg::PLANE_V) plane_pos = pyc_pkg::PLANE_Y;
		if (plane_pos == pyc_pkg::PLANE_Y) begin
			pw = w;
			ph = h;
			x0 = l;
			x1 = w - r;
			y0 = t;
			y1 = h - b;
		end else begin
			pw = w >> 1;
			ph = h >> 1;
			x0 = l >> 1;
			x1 = pw - (r >> 1);
			y0 = t >> 1;
			y1 = ph - (b >> 1);
		end
		if (col_pos >= x0 && col_pos < x1 && row_pos >= y0 && row_pos < y1) begin
			k.pix = pix;
			k.plane = plane_pos;
			k.last = plane_pos == pyc_pkg::PLANE_V && col_pos + 1 == x1 && row_pos + 1 == y1;
			kept_q.push_back(k);
		end
		// a counter past a shrunk bound wraps here too
		if (col_pos + 1 >= pw) begin
			col_pos = 0;
			if (row_pos + 1 >= ph) begin
				row_pos = 0;
				plane_pos = (plane_pos == pyc_pkg::PLANE_V) ? pyc_pkg::PLANE_Y
					: plane_pos + 1'b1;
			end else begin
				row_pos++;
			end
		end else begin
			col_pos++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		kept_byte_t want;
		if (!arst_n) begin
			width_reg = pyc_pkg::RST_IN_WIDTH;
			height_reg = pyc_pkg::RST_IN_HEIGHT;
			left_reg = '0;
			right_reg = '0;
			top_reg = '0;
			bottom_reg = '0;
			col_pos = 0;
			row_pos = 0;
			plane_pos = pyc_pkg::PLANE_Y;
			kept_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (kept_q.size() == 0) begin
					$error("unexpected output transfer: pixel_out %0d plane %0d last %0b",
						m_tdata, m_tuser, m_tlast);
					fail_count++;
				end else begin
					want = kept_q.pop_front();
					if (m_tdata !== want.pix) begin
						$error("pixel_out mismatch: expected %0d, actual %0d", want.pix, m_tdata);
						fail_count++;
					end
					if (m_tuser !== want.plane) begin
						$error("plane mismatch: expected %0d, actual %0d", want.plane, m_tuser);
						fail_count++;
					end
					if (m_tlast !== want.last) begin
						$error("last_of_frame mismatch: expected %0b, actual %0b",
							want.last, m_tlast);
						fail_count++;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					pyc_pkg::REG_IN_WIDTH:    width_reg = cfg_data;
					pyc_pkg::REG_IN_HEIGHT:   height_reg = cfg_data;
					pyc_pkg::REG_CROP_LEFT:   left_reg = cfg_data;
					pyc_pkg::REG_CROP_RIGHT:  right_reg = cfg_data;
					pyc_pkg::REG_CROP_TOP:    top_reg = cfg_data;
					pyc_pkg::REG_CROP_BOTTOM: bottom_reg = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) crop_step(s_tdata, s_tuser);
			pending = kept_q.size();
		end
	end

endmodule

>>> tb/planar_yuv420_crop_tb.sv
// Testbench top: clock, reset, stimulus for the crop block and the final verdict.
`timescale 1ns / 1ps
module planar_yuv420_crop_tb;

	localparam int MAX_DIM      = 4096;
	localparam int STALL_LIMIT  = 2000;
	localparam int RANDOM_ITEMS = 1950;

	localparam logic [pyc_pkg::IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [pyc_pkg::IDX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef enum {PH_SMALL, PH_WIDE, PH_TALL, PH_NOISE} phase_kind_t;
	typedef logic [pyc_pkg::CFG_W-1:0] cfg_word_t;
	typedef logic [pyc_pkg::PIX_W-1:0] pix_byte_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_we = 1'b0;
	logic [pyc_pkg::IDX_W-1:0]     cfg_index = '0;
	logic [pyc_pkg::CFG_W-1:0]     cfg_data = '0;
	logic                          s_axis_tvalid = 1'b0;
	logic                          s_axis_tready;
	logic [pyc_pkg::PIX_W-1:0]     s_axis_tdata = '0;
	logic                          s_axis_tuser = 1'b0;
	logic                          m_axis_tvalid;
	logic                          m_axis_tready = 1'b0;
	logic [pyc_pkg::PIX_W-1:0]     m_axis_tdata;
	logic [pyc_pkg::PLANE_W-1:0]   m_axis_tuser;
	logic                          m_axis_tlast;

	int fail_count;
	int pending;
	int items_sent = 0;
	int stall_cycles = 0;
	bit idle_on = 1'b1;

	always #5 clk = ~clk;

	planar_yuv420_crop #(
		.MAX_DIM(MAX_DIM)
	) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	planar_yuv420_crop_chk #(
		.MAX_DIM(MAX_DIM)
	) u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_axis_tvalid),
		.s_tready   (s_axis_tready),
		.s_tdata    (s_axis_tdata),
		.s_tuser    (s_axis_tuser),
		.m_tvalid   (m_axis_tvalid),
		.m_tready   (m_axis_tready),
		.m_tdata    (m_axis_tdata),
		.m_tuser    (m_axis_tuser),
		.m_tlast    (m_axis_tlast),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always @(negedge clk) begin
		m_axis_tready <= !(idle_on && $urandom_range(0, 99) < 20);
	end

	// End the run if no transfer happens for too long.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("planar_yuv420_crop verification failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic send_byte(input logic [pyc_pkg::PIX_W-1:0] pix, input logic start);
		while (idle_on && $urandom_range(0, 99) < 20) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= pix;
		s_axis_tuser <= start;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		items_sent++;
	endtask

	// Hold the input until every kept byte is out and the pipeline is empty.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_reg(input logic [pyc_pkg::IDX_W-1:0] idx,
			input logic [pyc_pkg::CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
	endtask

	task automatic load_window(input cfg_word_t w, input cfg_word_t h,
			input cfg_word_t l, input cfg_word_t r,
			input cfg_word_t t, input cfg_word_t b, input bit spare);
		if (spare) begin
			write_reg(REG_SPARE_LO, cfg_word_t'($urandom_range(0, 8191)));
			write_reg(REG_SPARE_HI, cfg_word_t'($urandom_range(0, 8191)));
		end
		write_reg(pyc_pkg::REG_IN_WIDTH, w);
		write_reg(pyc_pkg::REG_IN_HEIGHT, h);
		write_reg(pyc_pkg::REG_CROP_LEFT, l);
		write_reg(pyc_pkg::REG_CROP_RIGHT, r);
		write_reg(pyc_pkg::REG_CROP_TOP, t);
		write_reg(pyc_pkg::REG_CROP_BOTTOM, b);
		cfg_we <= 1'b0;
		// wait for the bound registers to take up the new values
		repeat (2) @(negedge clk);
	endtask

	// One whole frame of a small even size; a rare stray start breaks the sequence.
	task automatic send_frame(input int w, input int h, input bit mark_start);
		int len;
		len = w * h + (w / 2) * (h / 2) * 2;
		for (int i = 0; i < len; i++)
			send_byte(pix_byte_t'($urandom_range(0, 255)),
				(i == 0 && mark_start) || $urandom_range(0, 199) == 0);
	endtask

	task automatic send_run(input int n, input int start_odds);
		for (int i = 0; i < n; i++)
			send_byte(pix_byte_t'($urandom_range(0, 255)),
				i == 0 ? 1'($urandom_range(0, 3) != 0) : $urandom_range(0, start_odds - 1) == 0);
	endtask

	initial begin
		int phase;
		int nframes;
		phase_kind_t kind;
		cfg_word_t w, h, l, r, t, b;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// reset window: 640 x 480, nothing cropped
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b0);
		settle();
		// 2 x 2 frames, the second one without a start mark
		load_window(2, 2, 0, 0, 0, 0, 1'b1);
		for (int i = 0; i < 12; i++) send_byte(pix_byte_t'($urandom_range(0, 255)), i == 0);
		settle();
		// left crop equals width: nothing kept
		load_window(2, 2, 3, 0, 0, 0, 1'b0);
		for (int i = 0; i < 6; i++) send_byte(pix_byte_t'($urandom_range(0, 255)), i == 0);
		settle();
		// odd sizes become 2 x 2 (width rounds down, height is raised to the minimum), both crop pairs too large
		load_window(3, 1, 8191, 2, 5, 0, 1'b0);
		for (int i = 0; i < 6; i++) send_byte(pix_byte_t'($urandom_range(0, 255)), i == 0);

		items_sent = 0;
		for (phase = 0; items_sent < RANDOM_ITEMS; phase++) begin
			settle();
			idle_on = !(items_sent >= 700 && items_sent < 1100);
			if (phase == 0) kind = PH_WIDE;
			else if (phase == 1) kind = PH_SMALL;
			else begin
				case ($urandom_range(0, 9))
					7:       kind = PH_WIDE;
					8:       kind = PH_TALL;
					9:       kind = PH_NOISE;
					default: kind = PH_SMALL;
				endcase
			end
			case (kind)
				PH_SMALL: begin
					w = cfg_word_t'(2 * $urandom_range(1, 8));
					h = cfg_word_t'(2 * $urandom_range(1, 6));
					l = cfg_word_t'($urandom_range(0, w));
					r = cfg_word_t'(($urandom_range(0, 4) == 0) ? $urandom_range(0, w)
						: $urandom_range(0, w - l));
					t = cfg_word_t'($urandom_range(0, h));
					b = cfg_word_t'(($urandom_range(0, 4) == 0) ? $urandom_range(0, h)
						: $urandom_range(0, h - t));
					load_window(w, h, l, r, t, b, $urandom_range(0, 4) == 0);
					nframes = $urandom_range(1, 3);
					// phase 1 continues the large frame left by phase 0
					for (int f = 0; f < nframes; f++)
						send_frame(int'(w), int'(h),
							!(phase == 1 && f == 0) && $urandom_range(0, 7) != 0);
				end
				PH_WIDE: begin
					case ($urandom_range(0, 2))
						0:       w = 4096;
						1:       w = 8191;
						default: w = cfg_word_t'($urandom_range(2, 8191));
					endcase
					h = cfg_word_t'($urandom_range(0, 8191));
					l = cfg_word_t'($urandom_range(0, 1) ? $urandom_range(0, 8191)
						: $urandom_range(0, 40));
					r = cfg_word_t'($urandom_range(0, 1) ? $urandom_range(0, 8191)
						: $urandom_range(0, 40));
					t = cfg_word_t'($urandom_range(0, 8191));
					b = cfg_word_t'($urandom_range(0, 8191));
					load_window(w, h, l, r, t, b, 1'b0);
					send_run($urandom_range(20, 60), 1000);
				end
				PH_TALL: begin
					w = cfg_word_t'($urandom_range(0, 3));
					h = cfg_word_t'($urandom_range(0, 8191));
					l = cfg_word_t'($urandom_range(0, 3));
					r = cfg_word_t'($urandom_range(0, 3));
					t = cfg_word_t'($urandom_range(0, 1) ? $urandom_range(0, 8191)
						: $urandom_range(0, 12));
					b = cfg_word_t'($urandom_range(0, 8191));
					load_window(w, h, l, r, t, b, 1'b0);
					send_run($urandom_range(20, 60), 1000);
				end
				default: begin
					load_window(cfg_word_t'($urandom_range(0, 8191)),
						cfg_word_t'($urandom_range(0, 8191)),
						cfg_word_t'($urandom_range(0, 8191)),
						cfg_word_t'($urandom_range(0, 8191)),
						cfg_word_t'($urandom_range(0, 8191)),
						cfg_word_t'($urandom_range(0, 8191)), 1'b1);
					send_run($urandom_range(10, 60), 8);
				end
			endcase
		end

		idle_on = 1'b1;
		settle();
		if (fail_count == 0 && pending == 0) begin
			$display("planar_yuv420_crop verification clean");
		end else begin
			$display("planar_yuv420_crop verification failed");
		end
		$finish;
	end

endmodule
